>>> rtl/core/pfr_pkg.sv
// Shared types and constants of the page frame replacement unit.
`timescale 1ns / 1ps
package pfr_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int FRAMES_W   = 7;
  localparam int PERIOD_W   = 16;
  localparam int NCMP_W     = 9;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd2;

  localparam logic MODE_CLOCK = 1'b0;
  localparam logic MODE_NRU   = 1'b1;

  localparam logic [FRAMES_W-1:0] FRAMES_RESET = 7'd64;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd64;
  localparam logic [PERIOD_W-1:0] COUNT_MAX    = 16'hFFFF;

  typedef struct packed {
    logic load;
    logic look;
    logic pick;
    logic commit;
  } pfr_cmd_t;

  typedef struct packed {
    logic out_free;
  } pfr_stat_t;

endpackage

>>> rtl/core/pfr_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module pfr_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> rtl/core/pfr_ctrl.sv
// Sequencer of the replacement unit: accept, lookup, victim pick, commit.
`timescale 1ns / 1ps
module pfr_ctrl import pfr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  pfr_stat_t stat,
  output pfr_cmd_t  cmd
);

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_PICK, S_COMMIT} state_t;

  state_t state_r;

  assign in_ready   = (state_r == S_IDLE);
  assign cmd.load   = (state_r == S_IDLE) && in_valid;
  assign cmd.look   = (state_r == S_LOOK);
  assign cmd.pick   = (state_r == S_PICK);
  assign cmd.commit = (state_r == S_COMMIT) && stat.out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE:   if (in_valid) state_r <= S_LOOK;
        S_LOOK:   state_r <= S_PICK;
        S_PICK:   state_r <= S_COMMIT;
        S_COMMIT: if (stat.out_free) state_r <= S_IDLE;
        default:  state_r <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/pfr_dpath.sv
// Frame table, tag match, clock and NRU victim selection, result register.
`timescale 1ns / 1ps
module pfr_dpath import pfr_pkg::*; #(
  parameter int MAX_FRAMES = 64,
  parameter int PAGE_BITS  = 20,
  localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pfr_cmd_t              cmd,
  output pfr_stat_t             stat,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [PAGE_BITS-1:0]  in_page_number,
  input  logic                  in_is_write,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_hit,
  output logic [FW-1:0]         out_frame_used,
  output logic                  out_evicted_valid,
  output logic [PAGE_BITS-1:0]  out_evicted_page,
  output logic                  out_writeback
);

  logic                 mode_r;
  logic [FRAMES_W-1:0]  frames_r;
  logic [PERIOD_W-1:0]  period_r;

  logic [PAGE_BITS-1:0] page_r;
  logic                 wr_r;
  logic                 hit_r;
  logic [FW-1:0]        hidx_r;
  logic [FW-1:0]        victim_r;
  logic [FW-1:0]        hand_r;
  logic [PERIOD_W-1:0]  cnt_r;

  logic [MAX_FRAMES-1:0] valid_r, ref_r, dirty_r;
  logic [PAGE_BITS-1:0]  tag_r [MAX_FRAMES];

  logic                  out_valid_r, out_hit_r, out_ev_r, out_wb_r;
  logic [FW-1:0]         out_frame_r;
  logic [PAGE_BITS-1:0]  out_page_r;

  logic [NCMP_W-1:0]     n;
  logic [MAX_FRAMES-1:0] active, hitvec, cand, upper, clr_mask;
  logic [MAX_FRAMES-1:0] inv, c0, c1, c2;
  logic [FW-1:0]         hit_idx, h_start, f_up, f_any, clk_victim, nru_victim, vsel;
  logic [FW-1:0]         hand_nxt, ram_addr;
  logic                  refresh;
  logic [PAGE_BITS-1:0]  ram_rdata;

  function automatic logic [FW-1:0] first_set(input logic [MAX_FRAMES-1:0] v);
    logic [FW-1:0] idx;
    idx = '0;
    for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
      if (v[i]) idx = FW'(i);
    end
    return idx;
  endfunction

  always_comb begin
    if (frames_r == '0) begin
      n = NCMP_W'(1);
    end else if (NCMP_W'(frames_r) > NCMP_W'(MAX_FRAMES)) begin
      n = NCMP_W'(MAX_FRAMES);
    end else begin
      n = NCMP_W'(frames_r);
    end
  end

  always_comb begin
    h_start = (NCMP_W'(hand_r) >= n) ? '0 : hand_r;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      active[i] = NCMP_W'(i) < n;
      hitvec[i] = active[i] && valid_r[i] && (tag_r[i] == page_r);
      cand[i]   = active[i] && (!valid_r[i] || !ref_r[i]);
      upper[i]  = cand[i] && (FW'(i) >= h_start);
      inv[i]    = active[i] && !valid_r[i];
      c0[i]     = active[i] && !ref_r[i] && !dirty_r[i];
      c1[i]     = active[i] && !ref_r[i];
      c2[i]     = active[i] && !dirty_r[i];
    end
    hit_idx = first_set(hitvec);
    f_up    = first_set(upper);
    f_any   = first_set(cand);

    // No candidate: the hand sweeps once, clears every active reference bit and picks the frame where it began.
    if (|upper) begin
      clk_victim = f_up;
    end else if (|cand) begin
      clk_victim = f_any;
    end else begin
      clk_victim = h_start;
    end
    for (int i = 0; i < MAX_FRAMES; i++) begin
      if (!(|cand)) begin
        clr_mask[i] = active[i];
      end else if (clk_victim >= h_start) begin
        clr_mask[i] = (FW'(i) >= h_start) && (FW'(i) < clk_victim);
      end else begin
        clr_mask[i] = active[i] && ((FW'(i) >= h_start) || (FW'(i) < clk_victim));
      end
    end
    hand_nxt = ((NCMP_W'(clk_victim) + NCMP_W'(1)) >= n) ? '0 : (clk_victim + FW'(1));

    priority if (|inv) begin
      nru_victim = first_set(inv);
    end else if (|c0) begin
      nru_victim = first_set(c0);
    end else if (|c1) begin
      nru_victim = first_set(c1);
    end else if (|c2) begin
      nru_victim = first_set(c2);
    end else begin
      nru_victim = FW'(n - NCMP_W'(1));
    end

    vsel     = (mode_r == MODE_NRU) ? nru_victim : clk_victim;
    refresh  = (mode_r == MODE_NRU) && (cnt_r >= period_r);
    ram_addr = cmd.pick ? vsel : victim_r;
  end

  pfr_ram #(.WIDTH(PAGE_BITS), .DEPTH(MAX_FRAMES)) u_tag_ram (
    .clk   (clk),
    .we    (cmd.commit && !hit_r),
    .re    (cmd.pick && !hit_r),
    .addr  (ram_addr),
    .wdata (page_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_CLOCK;
      frames_r    <= FRAMES_RESET;
      period_r    <= PERIOD_RESET;
      valid_r     <= '0;
      ref_r       <= '0;
      dirty_r     <= '0;
      hand_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MODE:   mode_r   <= cfg_wdata[0];
          REG_FRAMES: frames_r <= cfg_wdata[FRAMES_W-1:0];
          REG_PERIOD: period_r <= cfg_wdata[PERIOD_W-1:0];
          default:    ;
        endcase
      end
      if (cmd.look && refresh) begin
        ref_r <= '0;
        cnt_r <= '0;
      end
      if (cmd.pick && !hit_r && (mode_r == MODE_CLOCK)) begin
        ref_r  <= ref_r & ~clr_mask;
        hand_r <= hand_nxt;
      end
      if (cmd.commit) begin
        if (hit_r) begin
          ref_r[hidx_r] <= 1'b1;
          if (wr_r) dirty_r[hidx_r] <= 1'b1;
        end else begin
          valid_r[victim_r] <= 1'b1;
          ref_r[victim_r]   <= 1'b1;
          dirty_r[victim_r] <= wr_r;
        end
        if (cnt_r != COUNT_MAX) cnt_r <= cnt_r + PERIOD_W'(1);
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      page_r <= in_page_number;
      wr_r   <= in_is_write;
    end
    if (cmd.look) begin
      hit_r  <= |hitvec;
      hidx_r <= hit_idx;
    end
    if (cmd.pick) begin
      victim_r <= vsel;
    end
    if (cmd.commit) begin
      if (!hit_r) tag_r[victim_r] <= page_r;
      out_hit_r   <= hit_r;
      out_frame_r <= hit_r ? hidx_r : victim_r;
      out_ev_r    <= !hit_r && valid_r[victim_r];
      out_page_r  <= (!hit_r && valid_r[victim_r]) ? ram_rdata : '0;
      out_wb_r    <= !hit_r && valid_r[victim_r] && dirty_r[victim_r];
    end
  end

  assign stat.out_free     = !out_valid_r || out_ready;
  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_frame_used    = out_frame_r;
  assign out_evicted_valid = out_ev_r;
  assign out_evicted_page  = out_page_r;
  assign out_writeback     = out_wb_r;

  a_miss_fills: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && !hit_r |=> valid_r[victim_r] && ref_r[victim_r])
    else $error("victim frame not filled after miss");
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_hit_r && out_ev_r))
    else $error("hit reported an eviction");
  a_wb_needs_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_wb_r |-> out_ev_r)
    else $error("writeback without eviction");
  a_hit_sets_ref: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && hit_r |=> ref_r[hidx_r])
    else $error("hit frame not referenced");

endmodule

>>> rtl/core/page_frame_replacement_clock_nru.sv
// Top level of the page frame replacement unit.
`timescale 1ns / 1ps
// Takes one access word (page number, write flag) and returns one result word:
// hit, frame used, and the evicted page with its writeback flag on a miss.
// Victims come from the clock hand (mode 0) or from NRU classes (mode 1),
// where all referenced bits are cleared every refresh_period accesses.
// Each access passes through accept, tag lookup across all frames, victim
// pick and table update, the update waiting while out_ready holds the result register;
// a new word is taken as soon as the sequencer is back in idle.
module page_frame_replacement_clock_nru import pfr_pkg::*; #(
  parameter int MAX_FRAMES = 64,
  parameter int PAGE_BITS  = 20,
  localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PAGE_BITS-1:0]  in_page_number,
  input  logic                  in_is_write,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_hit,
  output logic [FW-1:0]         out_frame_used,
  output logic                  out_evicted_valid,
  output logic [PAGE_BITS-1:0]  out_evicted_page,
  output logic                  out_writeback
);

  pfr_cmd_t  cmd;
  pfr_stat_t stat;

  pfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pfr_dpath #(.MAX_FRAMES(MAX_FRAMES), .PAGE_BITS(PAGE_BITS)) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_page_number    (in_page_number),
    .in_is_write       (in_is_write),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_hit           (out_hit),
    .out_frame_used    (out_frame_used),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_writeback     (out_writeback)
  );

endmodule

>>> dv/page_frame_replacement_clock_nru_test.sv
// Self-checking testbench for the clock / NRU page frame replacement unit.
`timescale 1ns / 1ps
module page_frame_replacement_clock_nru_test;
  import pfr_pkg::*;

  localparam int NF = 64;

  typedef struct packed {
    logic        hit;
    logic [5:0]  frame;
    logic        ev_valid;
    logic [19:0] ev_page;
    logic        wb;
  } access_result_t;

  class frame_table_board;
    logic        mode;
    int unsigned frames_cfg;
    int unsigned period;
    logic [19:0] tag [NF];
    bit          vld [NF];
    bit          refd [NF];
    bit          dirty [NF];
    int unsigned hand;
    int unsigned count;
    access_result_t pending [$];
    int errors;

    function void clear();
      mode = MODE_CLOCK;
      frames_cfg = 64;
      period = 64;
      for (int i = 0; i < NF; i++) begin
        tag[i] = '0; vld[i] = 0; refd[i] = 0; dirty[i] = 0;
      end
      hand = 0;
      count = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      if (idx == REG_MODE) mode = val[0];
      else if (idx == REG_FRAMES) frames_cfg = val[6:0];
      else if (idx == REG_PERIOD) period = val;
    endfunction

    function int unsigned victim_clock(int unsigned n);
      int unsigned h;
      int unsigned v;
      h = (hand >= n) ? 0 : hand;
      while (vld[h] && refd[h]) begin
        refd[h] = 0;
        h = (h + 1 >= n) ? 0 : h + 1;
      end
      v = h;
      hand = (h + 1 >= n) ? 0 : h + 1;
      return v;
    endfunction

    function int unsigned victim_nru(int unsigned n);
      for (int i = 0; i < n; i++) if (!vld[i]) return i;
      for (int i = 0; i < n; i++) if (!refd[i] && !dirty[i]) return i;
      for (int i = 0; i < n; i++) if (!refd[i]) return i;
      for (int i = 0; i < n; i++) if (!dirty[i]) return i;
      return n - 1;
    endfunction

    function void note_access(logic [19:0] page, logic wr);
      int unsigned n;
      int unsigned f;
      access_result_t r;
      n = (frames_cfg == 0) ? 1 : (frames_cfg > NF) ? NF : frames_cfg;
      r = '0;
      f = 0;
      if (mode == MODE_NRU && count >= period) begin
        for (int i = 0; i < NF; i++) refd[i] = 0;
        count = 0;
      end
      for (int i = 0; i < n; i++)
        if (vld[i] && tag[i] == page && !r.hit) begin
          r.hit = 1; f = i;
        end
      if (r.hit) begin
        refd[f] = 1;
        if (wr) dirty[f] = 1;
      end else begin
        f = (mode == MODE_NRU) ? victim_nru(n) : victim_clock(n);
        if (vld[f]) begin
          r.ev_valid = 1; r.ev_page = tag[f]; r.wb = dirty[f];
        end
        tag[f] = page; vld[f] = 1; refd[f] = 1; dirty[f] = wr;
      end
      if (count < 16'hFFFF) count++;
      r.frame = f[5:0];
      pending.push_back(r);
    endfunction

    function void report(string what, int got, int exp);
      $display("mismatch %s: got %0h expected %0h", what, got, exp);
      errors++;
    endfunction

    function void check_result(access_result_t got);
      access_result_t e;
      if (pending.size() == 0) begin
        $display("mismatch: unexpected result word");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.hit != e.hit) report("hit", got.hit, e.hit);
      if (got.frame != e.frame) report("frame_used", got.frame, e.frame);
      if (got.ev_valid != e.ev_valid) report("evicted_valid", got.ev_valid, e.ev_valid);
      if (got.ev_page != e.ev_page) report("evicted_page", got.ev_page, e.ev_page);
      if (got.wb != e.wb) report("writeback", got.wb, e.wb);
    endfunction
  endclass

  logic clk, rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic in_valid, in_ready, in_is_write;
  logic [19:0] in_page_number;
  logic out_valid, out_ready, out_hit, out_evicted_valid, out_writeback;
  logic [5:0] out_frame_used;
  logic [19:0] out_evicted_page;

  frame_table_board board;
  bit quiet;
  logic [19:0] pool [16];

  page_frame_replacement_clock_nru DUT (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // receiver: random stall bursts, none once quiet
  initial begin
    int gap;
    out_ready = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 7);
        out_ready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
      if (out_valid && out_ready)
        board.check_result({out_hit, out_frame_used, out_evicted_valid,
                            out_evicted_page, out_writeback});
    end
  end

  // hold valid across back-to-back words; drop it only for an idle burst
  task automatic send(logic [19:0] page, logic wr);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1;
    in_page_number <= page;
    in_is_write <= wr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_access(page, wr);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    board.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic random_phase(int items);
    logic [19:0] p;
    for (int k = 0; k < items; k++) begin
      if ($urandom_range(0, 9) < 8) p = pool[$urandom_range(0, 15)];
      else p = 20'($urandom);
      send(p, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    board = new();
    board.clear();
    quiet = 0;
    cfg_we = 0; cfg_index = '0; cfg_wdata = '0;
    in_valid = 0; in_page_number = '0; in_is_write = 0;
    rst_n = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: field extremes, hits, write hits, fill and eviction
    set_reg(REG_FRAMES, 4);
    send(20'h00000, 0);
    send(20'hFFFFF, 1);
    send(20'h00000, 1);
    send(20'hFFFFF, 0);
    send(20'h55555, 0);
    send(20'hAAAAA, 1);
    send(20'h12345, 0);
    send(20'h00000, 0);
    send(20'h54321, 1);
    send(20'hFFFFF, 0);
    drain();
    set_reg(REG_MODE, MODE_NRU);
    set_reg(REG_PERIOD, 0);
    send(20'h00001, 0);
    send(20'h00002, 1);
    send(20'h00003, 0);
    send(20'hFFFFF, 1);
    send(20'h00000, 0);
    drain();
    set_reg(REG_FRAMES, 1);
    send(20'h0000F, 1);
    send(20'h000F0, 0);
    drain();
    set_reg(REG_FRAMES, 0);
    send(20'h0000F, 0);
    drain();
    set_reg(REG_FRAMES, 127);
    send(20'h000F0, 0);
    drain();

    // random phases over several settings
    for (int ph = 0; ph < 8; ph++) begin
      for (int i = 0; i < 16; i++) pool[i] = 20'($urandom);
      set_reg(REG_MODE, ph[0]);
      case (ph)
        0: set_reg(REG_FRAMES, 64);
        1: set_reg(REG_FRAMES, 1);
        7: set_reg(REG_FRAMES, 64);
        default: set_reg(REG_FRAMES, 16'($urandom_range(2, 20)));
      endcase
      case (ph)
        1: set_reg(REG_PERIOD, 16'hFFFF);
        3: set_reg(REG_PERIOD, 1);
        default: set_reg(REG_PERIOD, 16'($urandom_range(2, 40)));
      endcase
      if (ph == 7) quiet = 1;
      random_phase(100);
      drain();
    end

    if (board.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> page_frame_replacement_clock_nru.f
rtl/core/pfr_pkg.sv
rtl/core/pfr_ram.sv
rtl/core/pfr_ctrl.sv
rtl/core/pfr_dpath.sv
rtl/core/page_frame_replacement_clock_nru.sv
dv/page_frame_replacement_clock_nru_test.sv
